>>> rtl/ilp_pkg.sv
`default_nettype none

package ilp_pkg;

  localparam int ACC_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int CHAR_WIDTH  = 8;
  localparam int RADIX_WIDTH = 5;
  localparam int POS_WIDTH   = 2;

  localparam logic [CHAR_WIDTH-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE       = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_LC_A       = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LC_F       = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CH_UC_A       = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UC_F       = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] CH_B          = 8'h62;
  localparam logic [CHAR_WIDTH-1:0] CH_O          = 8'h6F;
  localparam logic [CHAR_WIDTH-1:0] CH_D          = 8'h64;
  localparam logic [CHAR_WIDTH-1:0] CH_X          = 8'h78;

  localparam logic [RADIX_WIDTH-1:0] RADIX_NONE = 5'd0;
  localparam logic [RADIX_WIDTH-1:0] RADIX_BIN  = 5'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = 5'd8;
  localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = 5'd16;

  localparam logic [POS_WIDTH-1:0] POS_FIRST  = 2'd0;
  localparam logic [POS_WIDTH-1:0] POS_SECOND = 2'd1;
  localparam logic [POS_WIDTH-1:0] POS_THIRD  = 2'd2;
  localparam logic [POS_WIDTH-1:0] POS_LATER  = 2'd3;

  typedef logic [ACC_WIDTH-1:0] acc_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0]   pos;
    logic                   first_was_zero;
    logic [RADIX_WIDTH-1:0] prefix_radix;
    logic [RADIX_WIDTH-1:0] radix;
    acc_t                   acc;
    logic                   halted;
  } ilp_state_t;

  localparam ilp_state_t STATE_RESET = '{
    pos:            POS_FIRST,
    first_was_zero: 1'b0,
    prefix_radix:   RADIX_NONE,
    radix:          RADIX_DEC,
    acc:            '0,
    halted:         1'b0
  };

endpackage

`default_nettype wire

>>> rtl/ilp_if.sv
`default_nettype none

interface ilp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ilp_pkg::CHAR_WIDTH-1:0] char_code;
  logic                         is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface ilp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilp_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/ilp_char_step.sv
`default_nettype none

module ilp_char_step (
  input  wire ilp_pkg::ilp_state_t              cur,
  input  wire logic [ilp_pkg::CHAR_WIDTH-1:0]   char_code,
  output ilp_pkg::ilp_state_t                   nxt
);
  import ilp_pkg::*;

  logic                   clear_prefix;
  acc_t                   acc_base;
  logic                   halted_base;
  logic [RADIX_WIDTH-1:0] radix_eff;
  logic                   is_digit;
  logic [3:0]             digit;
  acc_t                   acc_scaled;
  acc_t                   digit_ext;

  // prefix recognized: restart on the third character in the named radix
  assign clear_prefix = (cur.pos == POS_THIRD) && (cur.prefix_radix != RADIX_NONE);
  assign acc_base     = clear_prefix ? '0 : cur.acc;
  assign halted_base  = clear_prefix ? 1'b0 : cur.halted;
  assign radix_eff    = clear_prefix ? cur.prefix_radix : cur.radix;

  always_comb begin
    is_digit = 1'b1;
    digit    = char_code[3:0];
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      digit = char_code[3:0];
    end else if ((char_code >= CH_LC_A && char_code <= CH_LC_F) ||
                 (char_code >= CH_UC_A && char_code <= CH_UC_F)) begin
      digit = 4'(char_code[3:0] + 4'd9);
    end else begin
      is_digit = 1'b0;
    end
  end

  always_comb begin
    case (radix_eff)
      RADIX_BIN: acc_scaled = {acc_base[ACC_WIDTH-2:0], 1'b0};
      RADIX_OCT: acc_scaled = {acc_base[ACC_WIDTH-4:0], 3'b000};
      RADIX_HEX: acc_scaled = {acc_base[ACC_WIDTH-5:0], 4'b0000};
      default:   acc_scaled = {acc_base[ACC_WIDTH-4:0], 3'b000}
                            + {acc_base[ACC_WIDTH-2:0], 1'b0};
    endcase
  end

  assign digit_ext = {{(ACC_WIDTH-4){1'b0}}, digit};

  always_comb begin
    nxt        = cur;
    nxt.acc    = acc_base;
    nxt.halted = halted_base;
    nxt.radix  = radix_eff;

    if (cur.pos == POS_FIRST) begin
      nxt.first_was_zero = (char_code == CH_ZERO);
    end else if (cur.pos == POS_SECOND && cur.first_was_zero) begin
      case (char_code)
        CH_B:    nxt.prefix_radix = RADIX_BIN;
        CH_O:    nxt.prefix_radix = RADIX_OCT;
        CH_D:    nxt.prefix_radix = RADIX_DEC;
        CH_X:    nxt.prefix_radix = RADIX_HEX;
        default: nxt.prefix_radix = RADIX_NONE;
      endcase
    end

    if (!halted_base && char_code != CH_UNDERSCORE) begin
      if (!is_digit) begin
        nxt.halted = 1'b1;
      end else begin
        nxt.acc = acc_scaled + digit_ext;
      end
    end

    if (cur.pos != POS_LATER) begin
      nxt.pos = POS_WIDTH'(cur.pos + 1'b1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/integer_literal_parser_unit.sv
// Integer literal parser. Send the literal one character per in_ch transaction,
// with is_final set on the last character; the literal's value comes out as one
// out_ch transaction, two's complement and wrapped modulo 2^64. A 0b, 0o, 0d or
// 0x head (lowercase, literal of three or more characters) selects radix 2, 8,
// 10 or 16, otherwise radix 10; underscores are skipped, digits 0-9/a-f/A-F
// count in any radix, and the first other character freezes the value. One
// character is taken every cycle unless in_ch stalls: each passes an input
// register and one shift-add accumulate step, and a final character's result
// then goes to the output register and is offered on out_ch. in_ch stalls
// only when a result waits in the output register, out_ch is not taking it,
// and the next character to retire is itself final.
`default_nettype none

module integer_literal_parser_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ilp_in_if.sink    in_ch,
  ilp_out_if.source out_ch
);
  import ilp_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [CHAR_WIDTH-1:0] s1_char_r;
  logic                  s1_fin_r;
  logic                  in_fire;
  logic                  s1_go;

  ilp_state_t            state_r, state_nxt;
  ilp_state_t            step_out;

  logic                  out_valid_r, out_valid_nxt;
  acc_t                  out_acc_r;

  ilp_char_step u_step (
    .cur       (state_r),
    .char_code (s1_char_r),
    .nxt       (step_out)
  );

  assign s1_go        = s1_valid_r && (!s1_fin_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_comb begin
    state_nxt = state_r;
    if (s1_go) begin
      state_nxt = s1_fin_r ? STATE_RESET : step_out;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_fin_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_ch.char_code;
      s1_fin_r  <= in_ch.is_final;
    end
    if (s1_go && s1_fin_r) begin
      out_acc_r <= step_out.acc;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = VALUE_WIDTH'(signed'(out_acc_r));

  a_final_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_fin_r |=> out_valid_r)
    else $error("final character retired without a result");

  a_final_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_fin_r |=> state_r.pos == POS_FIRST && state_r.acc == '0
                          && !state_r.halted && state_r.radix == RADIX_DEC)
    else $error("state not restored after literal end");

  a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_fin_r |=> state_r.pos != POS_FIRST)
    else $error("character position failed to advance");

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && s1_fin_r && out_valid_r)
    else $error("input stalled without a pending result");

  a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.radix == RADIX_BIN || state_r.radix == RADIX_OCT ||
    state_r.radix == RADIX_DEC || state_r.radix == RADIX_HEX)
    else $error("radix register holds an unsupported radix");

endmodule

`default_nettype wire

>>> bench/integer_literal_parser_unit_test.sv
module integer_literal_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  localparam int ITEM_GOAL     = 900;
  localparam int HOLD_CYCLES   = 200;
  localparam int HOLD_AT       = 15;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int IDLE_PCT      = 11;
  localparam int CALM_FROM     = 300;
  localparam int CALM_TO       = 500;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  fin;
    bit                    sync;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ilp_in_if  in_ch();
  ilp_out_if out_ch();

  integer_literal_parser_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  char_item_t              pending_chars[$];
  logic [VALUE_WIDTH-1:0]  value_q[$];
  ilp_state_t              lit_st = STATE_RESET;
  int                      errors = 0;
  int                      n_taken = 0;
  int                      n_results = 0;
  int                      hold_left = 0;
  bit                      hold_done = 1'b0;
  int                      quiet_cycles = 0;
  logic                    calm;

  assign calm = (n_taken >= CALM_FROM) && (n_taken < CALM_TO);

  // advances the literal state by one character; returns 1 with the value on the final one
  function automatic bit parse_char(input logic [CHAR_WIDTH-1:0] ch, input logic fin,
                                    output logic [VALUE_WIDTH-1:0] val);
    logic [4:0] dig;
    bit         is_dig;
    is_dig = 1'b1;
    dig = '0;
    val = '0;
    if (lit_st.pos == POS_THIRD && lit_st.prefix_radix != RADIX_NONE) begin
      lit_st.acc = '0;
      lit_st.halted = 1'b0;
      lit_st.radix = lit_st.prefix_radix;
    end
    if (lit_st.pos == POS_FIRST) begin
      lit_st.first_was_zero = (ch == CH_ZERO);
    end else if (lit_st.pos == POS_SECOND && lit_st.first_was_zero) begin
      case (ch)
        CH_B: lit_st.prefix_radix = RADIX_BIN;
        CH_O: lit_st.prefix_radix = RADIX_OCT;
        CH_D: lit_st.prefix_radix = RADIX_DEC;
        CH_X: lit_st.prefix_radix = RADIX_HEX;
        default: lit_st.prefix_radix = RADIX_NONE;
      endcase
    end
    if (ch >= CH_ZERO && ch <= CH_NINE) dig = 5'(ch - CH_ZERO);
    else if (ch >= CH_LC_A && ch <= CH_LC_F) dig = 5'(ch - CH_LC_A + 10);
    else if (ch >= CH_UC_A && ch <= CH_UC_F) dig = 5'(ch - CH_UC_A + 10);
    else is_dig = 1'b0;
    if (!lit_st.halted && ch != CH_UNDERSCORE) begin
      if (!is_dig) lit_st.halted = 1'b1;
      else lit_st.acc = acc_t'(lit_st.acc * acc_t'(lit_st.radix) + acc_t'(dig));
    end
    if (lit_st.pos != POS_LATER) lit_st.pos = lit_st.pos + 1'b1;
    if (!fin) return 1'b0;
    val = VALUE_WIDTH'($signed(lit_st.acc));
    lit_st = STATE_RESET;
    return 1'b1;
  endfunction

  task automatic add_char(input logic [CHAR_WIDTH-1:0] ch, input logic fin, input bit sync);
    char_item_t it;
    it.ch = ch;
    it.fin = fin;
    it.sync = sync;
    pending_chars.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
  endtask

  function automatic logic [CHAR_WIDTH-1:0] pick_digit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return CH_UNDERSCORE;
    if (r < 6) return CHAR_WIDTH'($urandom_range(0, 255));
    r = $urandom_range(0, 21);
    if (r < 10) return CHAR_WIDTH'(CH_ZERO + r);
    if (r < 16) return CHAR_WIDTH'(CH_LC_A + r - 10);
    return CHAR_WIDTH'(CH_UC_A + r - 16);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] pick_prefix_letter();
    case ($urandom_range(0, 3))
      0: return CH_B;
      1: return CH_O;
      2: return CH_D;
      default: return CH_X;
    endcase
  endfunction

  task automatic add_random_literal(input bit sync);
    int                    kind;
    int                    len;
    int                    r;
    logic [CHAR_WIDTH-1:0] body[$];
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      body.push_back(CH_ZERO);
      body.push_back(pick_prefix_letter());
      len = $urandom_range(1, 24);
      repeat (len) body.push_back(pick_digit());
    end else if (kind < 72) begin
      len = $urandom_range(1, 22);
      repeat (len) body.push_back(pick_digit());
    end else if (kind < 85) begin
      // one-, two- and three-character heads, uppercase prefix letters included
      body.push_back($urandom_range(0, 3) == 0 ? pick_digit() : CH_ZERO);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 5);
        if (r < 3) body.push_back(pick_prefix_letter());
        else if (r < 5) body.push_back(CHAR_WIDTH'(pick_prefix_letter() - 8'h20));
        else body.push_back(pick_digit());
      end
      if ($urandom_range(0, 1) == 1) body.push_back(pick_digit());
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) body.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
    end
    foreach (body[i]) add_char(body[i], i == body.size() - 1, sync && i == 0);
  endtask

  // stimulus
  initial begin
    int lit_idx;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.is_final = 1'b0;
    out_ch.ready = 1'b0;
    add_text("0x_fF");
    add_text("0b");
    add_text("0B1");
    add_text("0o7z9");
    add_text("0d19");
    add_text("0b101");
    add_char(8'hFF, 1'b1, 1'b0);
    lit_idx = 0;
    while (pending_chars.size() < ITEM_GOAL) begin
      add_random_literal(lit_idx == 30 || lit_idx == 70);
      lit_idx++;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // checked between edges so that the driver's updates have settled
    while (pending_chars.size() != 0 || in_ch.valid || value_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && value_q.size() == 0) begin
      $display("** integer_literal_parser_unit: PASSED **");
    end else begin
      $display("** integer_literal_parser_unit: FAILED **");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin : drive
    logic [VALUE_WIDTH-1:0] v;
    char_item_t             it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n_taken <= n_taken + 1;
        if (parse_char(in_ch.char_code, in_ch.is_final, v)) value_q.push_back(v);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_chars.size() != 0 && !(pending_chars[0].sync && value_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          it = pending_chars.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.char_code <= it.ch;
          in_ch.is_final <= it.fin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    logic [VALUE_WIDTH-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results <= n_results + 1;
      if (value_q.size() == 0) begin
        $error("unexpected result transaction: value %h", out_ch.value);
        errors++;
      end else begin
        want = value_q.pop_front();
        if (out_ch.value !== want) begin
          $error("value: expected %h, got %h", want, out_ch.value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("** integer_literal_parser_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

>>> files.f
rtl/ilp_pkg.sv
rtl/ilp_if.sv
rtl/ilp_char_step.sv
rtl/integer_literal_parser_unit.sv
bench/integer_literal_parser_unit_test.sv
